@@ hdl/ttf_pkg.sv @@
// ---------------------------------------------------------------------------
// ttf_pkg: shared types, constants and helpers for the tangent frame unit
// Holds vector formats and the per-stage payload structs.
// ---------------------------------------------------------------------------
package ttf_pkg;

  localparam int UNIT_ONE = 16384;

  // Vector product: 17b x 17b exact products, difference, sign fix
  typedef logic signed [35:0] prod_t;

  // Magnitude word after range alignment: below 2^30
  typedef logic [29:0] mag_t;

  // Sum of three squared aligned magnitudes fits in 62 bits
  typedef logic [61:0] sq_t;

  // Square root of sq_t fits in 31 bits
  typedef logic [30:0] root_t;

  // Side-band that travels beside the vector data
  typedef struct packed {
    logic [31:0] index_a;
    logic [31:0] index_b;
    logic [31:0] index_c;
    logic        base_neg;
    logic        det_zero;
    logic [47:0] normal;
  } side_t;

  // Sign-extend one 16-bit lane of a packed word
  function automatic logic signed [16:0] lane16(input logic [47:0] w, input int unsigned sel);
    logic [15:0] v;
    v = w[sel*16 +: 16];
    return {v[15], v};
  endfunction

endpackage

@@ hdl/ttf_isqrt.sv @@
// ---------------------------------------------------------------------------
// ttf_isqrt: pipelined integer square root
// Restoring square root, one result bit per stage, floor of sqrt.
// ---------------------------------------------------------------------------
module ttf_isqrt
  import ttf_pkg::*;
#(
  parameter int DW = 62,
  parameter int TW = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic [DW-1:0]   rad,
  input  logic [TW-1:0]   tag_in,
  output logic [DW/2-1:0] root,
  output logic [TW-1:0]   tag_out
);

  localparam int RW = DW / 2;

  logic [DW-1:0] rem_r  [RW+1];
  logic [RW-1:0] q_r    [RW+1];
  logic [DW-1:0] rad_r  [RW+1];
  logic [TW-1:0] tag_r  [RW+1];

  always_comb begin
    rem_r[0] = '0;
    q_r[0]   = '0;
    rad_r[0] = rad;
    tag_r[0] = tag_in;
  end

  // One bit per stage: trial subtract of (4q+1) against shifted remainder
  for (genvar s = 0; s < RW; s++) begin : g_st
    logic [DW-1:0] rem_nxt_r;
    logic [RW-1:0] q_nxt_r;
    logic [DW-1:0] rad_nxt_r;
    logic [TW-1:0] tag_nxt_r;
    logic [DW+1:0] trial;
    logic [DW+1:0] cur;
    always_comb begin
      cur   = {rem_r[s], rad_r[s][DW-1 -: 2]};
      trial = {{(DW-RW){1'b0}}, q_r[s], 2'b01};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (cur >= trial) begin
          rem_nxt_r <= DW'(cur - trial);
          q_nxt_r   <= {q_r[s][RW-2:0], 1'b1};
        end else begin
          rem_nxt_r <= DW'(cur);
          q_nxt_r   <= {q_r[s][RW-2:0], 1'b0};
        end
        rad_nxt_r <= {rad_r[s][DW-3:0], 2'b00};
        tag_nxt_r <= tag_r[s];
      end
    end
    always_comb begin
      rem_r[s+1] = rem_nxt_r;
      q_r[s+1]   = q_nxt_r;
      rad_r[s+1] = rad_nxt_r;
      tag_r[s+1] = tag_nxt_r;
    end
  end

  assign root    = q_r[RW];
  assign tag_out = tag_r[RW];

  logic unused_rst;
  assign unused_rst = rst_n;

endmodule

@@ hdl/ttf_divq.sv @@
// ---------------------------------------------------------------------------
// ttf_divq: pipelined quotient floor((m*32768 + L) / (2L))
// Restoring division, one quotient bit per stage; quotient <= 16384.
// ---------------------------------------------------------------------------
module ttf_divq
  import ttf_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  logic [29:0] mag,
  input  logic [30:0] len,
  output logic [14:0] quo
);

  // Numerator m*2^15 + L < 2^46; divisor 2L < 2^32; quotient < 2^15
  localparam int QB = 15;
  localparam int NW = 46;

  logic [NW-1:0] num_s [QB+1];
  logic [31:0]   div_s [QB+1];
  logic [QB-1:0] q_s   [QB+1];

  always_comb begin
    num_s[0] = {1'b0, mag, 15'd0} + NW'(len);
    div_s[0] = {len, 1'b0};
    q_s[0]   = '0;
  end

  for (genvar s = 0; s < QB; s++) begin : g_st
    localparam int SH = QB - 1 - s;
    logic [NW-1:0] n_r;
    logic [31:0]   d_r;
    logic [QB-1:0] q_r;
    logic [NW+QB-1:0] sub;
    always_comb sub = {{QB{1'b0}}, div_s[s]} << SH;
    always_ff @(posedge clk) begin
      if (en) begin
        if ({{QB{1'b0}}, num_s[s]} >= sub) begin
          n_r <= NW'({{QB{1'b0}}, num_s[s]} - sub);
          q_r <= q_s[s] | (QB'(1) << SH);
        end else begin
          n_r <= num_s[s];
          q_r <= q_s[s];
        end
        d_r <= div_s[s];
      end
    end
    always_comb begin
      num_s[s+1] = n_r;
      div_s[s+1] = d_r;
      q_s[s+1]   = q_r;
    end
  end

  assign quo = q_s[QB];

endmodule

@@ hdl/ttf_norm.sv @@
// ---------------------------------------------------------------------------
// ttf_norm: vector normalizer to Q2.14
// Align stage, square/sum stages, pipelined root and division.
// ---------------------------------------------------------------------------
module ttf_norm
  import ttf_pkg::*;
#(
  parameter int TW = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  prod_t               vin [3],
  input  logic [TW-1:0]       tag_in,
  output logic signed [15:0]  vout [3],
  output logic                is_zero,
  output logic [TW-1:0]       tag_out
);

  localparam int LAT_SQ = 31;
  localparam int LAT_DV = 15;

  // Stage 1: magnitudes and leading-one position
  logic [35:0] m1_r [3];
  logic [2:0]  s1_neg_r;
  logic [TW-1:0] tag1_r;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        m1_r[i]     <= vin[i][35] ? 36'(-vin[i]) : 36'(vin[i]);
        s1_neg_r[i] <= vin[i][35];
      end
      tag1_r <= tag_in;
    end
  end

  logic [35:0] mx1;
  logic [5:0]  lead1;
  always_comb begin
    mx1 = m1_r[0] | m1_r[1] | m1_r[2];
    lead1 = '0;
    for (int b = 0; b < 36; b++) if (mx1[b]) lead1 = 6'(b);
  end

  // Stage 2: align so max lies in [2^29, 2^30)
  mag_t  m2_r [3];
  logic  z2_r;
  logic [2:0] s2_neg_r;
  logic [TW-1:0] tag2_r;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (lead1 >= 6'd29) m2_r[i] <= 30'(m1_r[i] >> (lead1 - 6'd29));
        else                m2_r[i] <= 30'(m1_r[i] << (6'd29 - lead1));
      end
      z2_r     <= (mx1 == '0);
      s2_neg_r <= s1_neg_r;
      tag2_r   <= tag1_r;
    end
  end

  // Stage 3: squares
  logic [59:0] sq3_r [3];
  mag_t  m3_r [3];
  logic  z3_r;
  logic [2:0] s3_neg_r;
  logic [TW-1:0] tag3_r;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) sq3_r[i] <= 60'(m2_r[i]) * 60'(m2_r[i]);
      m3_r <= m2_r; z3_r <= z2_r; s3_neg_r <= s2_neg_r; tag3_r <= tag2_r;
    end
  end

  // Stage 4: sum
  sq_t   sum4_r;
  mag_t  m4_r [3];
  logic  z4_r;
  logic [2:0] s4_neg_r;
  logic [TW-1:0] tag4_r;
  always_ff @(posedge clk) begin
    if (en) begin
      sum4_r <= 62'(sq3_r[0]) + 62'(sq3_r[1]) + 62'(sq3_r[2]);
      m4_r <= m3_r; z4_r <= z3_r; s4_neg_r <= s3_neg_r; tag4_r <= tag3_r;
    end
  end

  // Delay line for mags and side data across the root
  localparam int SW = 90 + 1 + 3 + TW;
  logic [SW-1:0] sd_line [LAT_SQ+1];
  assign sd_line[0] = {m4_r[0], m4_r[1], m4_r[2], z4_r, s4_neg_r, tag4_r};
  for (genvar k = 0; k < LAT_SQ; k++) begin : g_dl
    logic [SW-1:0] d_r;
    always_ff @(posedge clk) if (en) d_r <= sd_line[k];
    assign sd_line[k+1] = d_r;
  end

  root_t len;
  logic [0:0] unused_tag;
  ttf_isqrt #(.DW(62), .TW(1)) u_sqrt (
    .clk, .rst_n, .en, .rad(sum4_r), .tag_in(1'b0), .root(len), .tag_out(unused_tag)
  );

  mag_t m5 [3];
  logic z5;
  logic [2:0] s5_neg;
  logic [TW-1:0] tag5;
  assign {m5[0], m5[1], m5[2], z5, s5_neg, tag5} = sd_line[LAT_SQ];

  // Zero length guarded: use 1 to keep divider sane
  root_t len_safe;
  assign len_safe = z5 ? root_t'(1) : len;

  logic [14:0] q6 [3];
  for (genvar i = 0; i < 3; i++) begin : g_div
    ttf_divq u_div (.clk, .en, .mag(m5[i]), .len(len_safe), .quo(q6[i]));
  end

  localparam int SW2 = 1 + 3 + TW;
  logic [SW2-1:0] sd2 [LAT_DV+1];
  assign sd2[0] = {z5, s5_neg, tag5};
  for (genvar k = 0; k < LAT_DV; k++) begin : g_dl2
    logic [SW2-1:0] d_r;
    always_ff @(posedge clk) if (en) d_r <= sd2[k];
    assign sd2[k+1] = d_r;
  end

  logic z6;
  logic [2:0] s6_neg;
  assign {z6, s6_neg, tag_out} = sd2[LAT_DV];
  assign is_zero = z6;

  // Clamp, sign and zero select
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic [14:0] q;
      q = (q6[i] > 15'(UNIT_ONE)) ? 15'(UNIT_ONE) : q6[i];
      if (z6)            vout[i] = '0;
      else if (s6_neg[i]) vout[i] = -$signed({1'b0, q});
      else               vout[i] = $signed({1'b0, q});
    end
  end

endmodule

@@ hdl/triangle_tangent_frame_unit.sv @@
// ---------------------------------------------------------------------------
// triangle_tangent_frame_unit: per-triangle tangent frame generator
// Delta/product front end, two normalizers, handedness back end.
// ---------------------------------------------------------------------------
// Accepts one triangle word per cycle while not stalled and returns one result
// word per triangle, in order. From the accepting edge to the
// result on the output lie three front-end stages, the normalizer's 50
// stages (four align/square/sum stages, a 31-stage square root pipeline and
// a 15-stage quotient pipeline), two handedness stages and the output
// register. The whole pipeline advances whenever the output register is
// empty or being taken, so a stall freezes every stage.
module triangle_tangent_frame_unit
  import ttf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_left_handed,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [47:0] in_position_a,
  input  logic [47:0] in_position_b,
  input  logic [47:0] in_position_c,
  input  logic [31:0] in_uv_a,
  input  logic [31:0] in_uv_b,
  input  logic [31:0] in_uv_c,
  input  logic [47:0] in_normal_a,
  input  logic [31:0] in_index_a,
  input  logic [31:0] in_index_b,
  input  logic [31:0] in_index_c,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [15:0] out_tangent_x,
  output logic signed [15:0] out_tangent_y,
  output logic signed [15:0] out_tangent_z,
  output logic        out_handedness_negative,
  output logic        out_degenerate,
  output logic [31:0] out_index_a,
  output logic [31:0] out_index_b,
  output logic [31:0] out_index_c
);

  localparam int NLAT = 4 + 31 + 15;  // normalizer latency
  localparam int SIDE_W = $bits(side_t);

  logic en;
  logic left_handed_r;

  // Config register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) left_handed_r <= 1'b0;
    else if (cfg_valid) left_handed_r <= cfg_left_handed;
  end

  // Stage A: deltas
  logic signed [16:0] e1_r [3], e2_r [3];
  logic signed [16:0] d1u_r, d1v_r, d2u_r, d2v_r;
  side_t sa_r;
  logic  va_r;
  always_ff @(posedge clk) begin
    if (!rst_n) va_r <= 1'b0;
    else if (en) va_r <= in_valid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        e1_r[i] <= lane16(in_position_b, i) - lane16(in_position_a, i);
        e2_r[i] <= lane16(in_position_c, i) - lane16(in_position_a, i);
      end
      d1u_r <= lane16({16'd0, in_uv_b}, 0) - lane16({16'd0, in_uv_a}, 0);
      d1v_r <= lane16({16'd0, in_uv_b}, 1) - lane16({16'd0, in_uv_a}, 1);
      d2u_r <= lane16({16'd0, in_uv_c}, 0) - lane16({16'd0, in_uv_a}, 0);
      d2v_r <= lane16({16'd0, in_uv_c}, 1) - lane16({16'd0, in_uv_a}, 1);
      sa_r  <= '{index_a: in_index_a, index_b: in_index_b, index_c: in_index_c,
                 base_neg: ~left_handed_r, det_zero: 1'b0, normal: in_normal_a};
    end
  end

  // Stage B: products
  logic signed [33:0] pt1_r [3], pt2_r [3], pb1_r [3], pb2_r [3];
  logic signed [33:0] pd1_r, pd2_r;
  side_t sb_r;
  logic  vb_r;
  always_ff @(posedge clk) begin
    if (!rst_n) vb_r <= 1'b0;
    else if (en) vb_r <= va_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pt1_r[i] <= d2v_r * e1_r[i];
        pt2_r[i] <= d1v_r * e2_r[i];
        pb1_r[i] <= d1u_r * e2_r[i];
        pb2_r[i] <= d2u_r * e1_r[i];
      end
      pd1_r <= d1u_r * d2v_r;
      pd2_r <= d2u_r * d1v_r;
      sb_r  <= sa_r;
    end
  end

  // Stage C: differences, determinant sign
  prod_t tv_r [3], bv_r [3];
  side_t sc_r;
  logic  vc_r;
  always_ff @(posedge clk) begin
    if (!rst_n) vc_r <= 1'b0;
    else if (en) vc_r <= vb_r;
  end
  logic signed [34:0] det_c;
  assign det_c = 35'(pd1_r) - 35'(pd2_r);

  // Side-band with the zero-determinant mark filled in
  side_t sc_nxt;
  always_comb begin
    sc_nxt          = sb_r;
    sc_nxt.det_zero = (det_c == '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        logic signed [35:0] t, b;
        t = 36'(pt1_r[i]) - 36'(pt2_r[i]);
        b = 36'(pb1_r[i]) - 36'(pb2_r[i]);
        tv_r[i] <= det_c[34] ? -t : t;
        bv_r[i] <= det_c[34] ? -b : b;
      end
      sc_r <= sc_nxt;
    end
  end

  // Normalizers; a copy of valid rides the tag but goes unused
  logic signed [15:0] tu [3], bu [3];
  logic t_zero, b_zero;
  logic [SIDE_W:0] tag_t;
  logic [0:0] tag_b;
  ttf_norm #(.TW(SIDE_W + 1)) u_norm_t (
    .clk, .rst_n, .en, .vin(tv_r), .tag_in({vc_r, sc_r}),
    .vout(tu), .is_zero(t_zero), .tag_out(tag_t)
  );
  ttf_norm #(.TW(1)) u_norm_b (
    .clk, .rst_n, .en, .vin(bv_r), .tag_in(1'b0),
    .vout(bu), .is_zero(b_zero), .tag_out(tag_b)
  );

  // Valid through the normalizer is reset-cleared separately
  logic [NLAT-1:0] vn_r;
  always_ff @(posedge clk) begin
    if (!rst_n) vn_r <= '0;
    else if (en) vn_r <= {vn_r[NLAT-2:0], vc_r};
  end

  side_t sn;
  assign sn = tag_t[SIDE_W-1:0];

  // Stage D: cross product n x t
  logic signed [32:0] cr_r [3];
  logic signed [15:0] td_r [3], bd_r [3];
  logic degen_d_r;
  side_t sd_r;
  logic vd_r;
  logic signed [16:0] nx, ny, nz;
  assign nx = lane16(sn.normal, 0);
  assign ny = lane16(sn.normal, 1);
  assign nz = lane16(sn.normal, 2);
  always_ff @(posedge clk) begin
    if (!rst_n) vd_r <= 1'b0;
    else if (en) vd_r <= vn_r[NLAT-1];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      cr_r[0] <= 33'(ny * tu[2]) - 33'(nz * tu[1]);
      cr_r[1] <= 33'(nz * tu[0]) - 33'(nx * tu[2]);
      cr_r[2] <= 33'(nx * tu[1]) - 33'(ny * tu[0]);
      td_r <= tu;
      bd_r <= bu;
      degen_d_r <= sn.det_zero | t_zero;
      sd_r <= sn;
    end
  end

  // Stage E: dot products
  logic signed [48:0] dp_r [3];
  logic signed [15:0] te_r [3];
  logic degen_e_r;
  side_t se_r;
  logic ve_r;
  always_ff @(posedge clk) begin
    if (!rst_n) ve_r <= 1'b0;
    else if (en) ve_r <= vd_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) dp_r[i] <= 49'(cr_r[i] * bd_r[i]);
      te_r <= td_r; degen_e_r <= degen_d_r; se_r <= sd_r;
    end
  end

  // Output register
  logic signed [50:0] dot_e;
  assign dot_e = 51'(dp_r[0]) + 51'(dp_r[1]) + 51'(dp_r[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else if (en) out_valid <= ve_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      out_tangent_x <= degen_e_r ? '0 : te_r[0];
      out_tangent_y <= degen_e_r ? '0 : te_r[1];
      out_tangent_z <= degen_e_r ? '0 : te_r[2];
      out_degenerate <= degen_e_r;
      out_handedness_negative <= se_r.base_neg ^ (~degen_e_r & dot_e[50]);
      out_index_a <= se_r.index_a;
      out_index_b <= se_r.index_b;
      out_index_c <= se_r.index_c;
    end
  end

  // Pipeline advances when output slot is free or being taken
  assign en = ~out_valid | out_ready;
  assign in_ready = en;

  logic unused;
  assign unused = ^{tag_t[SIDE_W], tag_b, b_zero};

endmodule

@@ hdl/ttf_checker.sv @@
// ---------------------------------------------------------------------------
// ttf_checker: port-level checks for the tangent frame unit
// Handshake stability and result field sanity.
// ---------------------------------------------------------------------------
module ttf_checker (
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_ready,
  input logic in_ready,
  input logic out_degenerate,
  input logic signed [15:0] out_tangent_x,
  input logic signed [15:0] out_tangent_y,
  input logic signed [15:0] out_tangent_z
);

  // Stalled word stays valid and its tangent x holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_tangent_x))
    else $error("stalled word changed");

  // Degenerate word carries zero tangent
  a_degen: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |->
      out_tangent_x == 0 && out_tangent_y == 0 && out_tangent_z == 0)
    else $error("degenerate with nonzero tangent");

  // Input side never blocks while output is free
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

endmodule

bind triangle_tangent_frame_unit ttf_checker u_ttf_checker (.*);
